// ----- src/ffba_pkg.sv -----
// ffba_pkg: shared types and constants for the first-fit block allocator
// holds the item structs, header word layout, op codes and state encoding
// no dependencies
`default_nettype none

package ffba_pkg;

	localparam int HEAP_BYTES = 4096;
	localparam int HDR_BYTES  = 16;
	localparam int ADDR_W     = 12;
	localparam int SIZE_W     = 13;
	localparam int CUR_W      = 14;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_RELEASE = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_SPLIT
	} state_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [12:0] request_bytes;
		logic [31:0] free_address;
	} cmd_t;

	typedef struct packed {
		logic [31:0] data_address;
		logic        status;
	} result_t;

	typedef struct packed {
		logic              busy;
		logic [SIZE_W-1:0] size;
	} hdr_t;

endpackage

`default_nettype wire

// ----- src/first_fit_block_allocator.sv -----
// first_fit_block_allocator: first-fit allocator over an implicit block list
// one item in flight; one header memory read per cycle drives the walk
// depends on ffba_pkg
// release and unused op give their result in the cycle after acceptance;
// allocate and free walk the block list header by header, with a split allocate also
// passing through the split state; the walk is paced by the single header read port
// throughput: one item at a time, the next is taken once busy falls
// reset: heap top and base address clear; the header memory is not cleared
`default_nettype none

module first_fit_block_allocator (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire ffba_pkg::cmd_t    cmd,
	output logic                   done,
	output ffba_pkg::result_t      result,
	input  wire logic              base_we,
	input  wire logic [31:0]       base_wdata
);

	ffba_pkg::state_t state_q, state_d;

	logic [1:0]                    op_q;
	logic [ffba_pkg::SIZE_W-1:0]   req_q;
	logic [31:0]                   off_q;
	logic [ffba_pkg::CUR_W-1:0]    cur_q, cur_d;
	logic [ffba_pkg::SIZE_W-1:0]   top_q, top_d;
	logic [31:0]                   base_q;
	logic                          done_q;
	ffba_pkg::result_t             result_q;

	// header memory
	ffba_pkg::hdr_t                hdr_mem [ffba_pkg::HEAP_BYTES];
	ffba_pkg::hdr_t                rd_data_q;
	logic [ffba_pkg::ADDR_W-1:0]   raddr, waddr;
	logic                          we;
	ffba_pkg::hdr_t                wdata;

	logic                          accept;
	logic                          in_range, fits, split, match_free, room;
	logic [ffba_pkg::CUR_W-1:0]    next_cur, split_off;
	logic [ffba_pkg::SIZE_W-1:0]   spare;
	logic [14:0]                   append_end;
	logic                          fin, fin_status;
	logic [31:0]                   fin_addr;

	assign accept     = start && (state_q == ffba_pkg::ST_IDLE);
	assign busy       = (state_q != ffba_pkg::ST_IDLE);
	assign done       = done_q;
	assign result     = result_q;

	assign in_range   = cur_q < {1'b0, top_q};
	assign fits       = !rd_data_q.busy && (rd_data_q.size >= req_q);
	assign spare      = rd_data_q.size - req_q;
	assign split      = spare > ffba_pkg::SIZE_W'(ffba_pkg::HDR_BYTES);
	assign match_free = {18'd0, cur_q} == off_q;
	assign next_cur   = cur_q + ffba_pkg::CUR_W'(ffba_pkg::HDR_BYTES) + {1'b0, rd_data_q.size};
	assign split_off  = cur_q + ffba_pkg::CUR_W'(ffba_pkg::HDR_BYTES) + {1'b0, req_q};
	assign append_end = {2'b00, top_q} + 15'(ffba_pkg::HDR_BYTES) + {2'b00, req_q};
	assign room       = append_end <= 15'(ffba_pkg::HEAP_BYTES);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ffba_pkg::ST_IDLE: begin
				if (accept && (cmd.op == ffba_pkg::OP_ALLOC || cmd.op == ffba_pkg::OP_FREE)) begin
					state_d = ffba_pkg::ST_WALK;
				end
			end
			ffba_pkg::ST_WALK: begin
				if (!in_range) begin
					state_d = ffba_pkg::ST_IDLE;
				end else if (op_q == ffba_pkg::OP_ALLOC && fits) begin
					state_d = split ? ffba_pkg::ST_SPLIT : ffba_pkg::ST_IDLE;
				end else if (op_q == ffba_pkg::OP_FREE && match_free) begin
					state_d = ffba_pkg::ST_IDLE;
				end
			end
			ffba_pkg::ST_SPLIT: begin
				state_d = ffba_pkg::ST_IDLE;
			end
			default: begin
				state_d = ffba_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs and datapath control
	always_comb begin
		fin        = 1'b0;
		fin_status = 1'b0;
		fin_addr   = '0;
		we         = 1'b0;
		waddr      = '0;
		wdata      = '0;
		raddr      = '0;
		top_d      = top_q;
		cur_d      = cur_q;
		unique case (state_q)
			ffba_pkg::ST_IDLE: begin
				cur_d = '0;
				if (accept) begin
					if (cmd.op == ffba_pkg::OP_RELEASE) begin
						top_d = '0;
						fin   = 1'b1;
					end else if (cmd.op == ffba_pkg::OP_NONE) begin
						fin = 1'b1;
					end
				end
			end
			ffba_pkg::ST_WALK: begin
				raddr = next_cur[ffba_pkg::ADDR_W-1:0];
				if (!in_range) begin
					fin = 1'b1;
					if (op_q == ffba_pkg::OP_ALLOC) begin
						if (room) begin
							we         = 1'b1;
							waddr      = top_q[ffba_pkg::ADDR_W-1:0];
							wdata.busy = 1'b1;
							wdata.size = req_q;
							top_d      = append_end[ffba_pkg::SIZE_W-1:0];
							fin_addr   = base_q + 32'(top_q) + 32'(ffba_pkg::HDR_BYTES);
						end else begin
							fin_status = 1'b1;
						end
					end
				end else if (op_q == ffba_pkg::OP_ALLOC && fits) begin
					we = 1'b1;
					if (split) begin
						waddr      = split_off[ffba_pkg::ADDR_W-1:0];
						wdata.busy = 1'b0;
						wdata.size = spare - ffba_pkg::SIZE_W'(ffba_pkg::HDR_BYTES);
					end else begin
						waddr      = cur_q[ffba_pkg::ADDR_W-1:0];
						wdata.busy = 1'b1;
						wdata.size = rd_data_q.size;
						fin        = 1'b1;
						fin_addr   = base_q + 32'(cur_q) + 32'(ffba_pkg::HDR_BYTES);
					end
				end else if (op_q == ffba_pkg::OP_FREE && match_free) begin
					we         = 1'b1;
					waddr      = cur_q[ffba_pkg::ADDR_W-1:0];
					wdata.busy = 1'b0;
					wdata.size = rd_data_q.size;
					fin        = 1'b1;
				end else begin
					cur_d = next_cur;
				end
			end
			ffba_pkg::ST_SPLIT: begin
				we         = 1'b1;
				waddr      = cur_q[ffba_pkg::ADDR_W-1:0];
				wdata.busy = 1'b1;
				wdata.size = req_q;
				fin        = 1'b1;
				fin_addr   = base_q + 32'(cur_q) + 32'(ffba_pkg::HDR_BYTES);
			end
			default: begin
				cur_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffba_pkg::ST_IDLE;
			cur_q   <= '0;
			top_q   <= '0;
			base_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cur_q   <= cur_d;
			top_q   <= top_d;
			done_q  <= fin;
			if (base_we) begin
				base_q <= base_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= cmd.op;
			req_q <= cmd.request_bytes;
			off_q <= cmd.free_address - base_q - 32'(ffba_pkg::HDR_BYTES);
		end
		if (fin) begin
			result_q.data_address <= fin_addr;
			result_q.status       <= fin_status;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			hdr_mem[waddr] <= wdata;
		end
		rd_data_q <= hdr_mem[raddr];
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still working");

	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= ffba_pkg::SIZE_W'(ffba_pkg::HEAP_BYTES))
		else $error("heap top beyond heap end");

	a_we_busy: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> busy)
		else $error("header write while idle");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status) |-> (result.data_address == 32'd0))
		else $error("failed allocate with nonzero address");

	a_split_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffba_pkg::ST_SPLIT) |=> done)
		else $error("split allocate gave no result");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// tb: self-checking testbench for first_fit_block_allocator
// directed table then random phases under several base addresses, each item checked
// against its table value or an in-bench first-fit heap predictor; depends on ffba_pkg and the dut
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ffba_pkg::*;

	localparam int PHASE_ITEMS = 250;
	localparam int NUM_PHASES  = 7;
	localparam int DRAIN_CYCLES = 300;

	typedef struct {
		op_t         op;
		logic [12:0] req;
		logic [31:0] faddr;
		bit          known;
		logic [31:0] want_addr;
		logic        want_status;
	} dir_row_t;

	localparam int DIR_ROWS = 22;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	cmd_t        cmd = '0;
	logic        done;
	result_t     result;
	logic        base_we = 1'b0;
	logic [31:0] base_wdata = '0;

	hdr_t        hdr_mem [HEAP_BYTES];
	int unsigned heap_top = 0;
	logic [31:0] heap_base = '0;

	result_t     pending_results [$];
	int unsigned live_blocks [$];
	int          fault_count = 0;
	bit          idle_on = 1'b1;

	dir_row_t dir_tab [DIR_ROWS] = '{
		'{OP_ALLOC,   13'd0,    32'd0,           1'b1, 32'd16, 1'b0},
		'{OP_ALLOC,   13'd4096, 32'd0,           1'b1, 32'd0,  1'b1},
		'{OP_FREE,    13'd0,    32'd16,          1'b1, 32'd0,  1'b0},
		'{OP_FREE,    13'd0,    32'd16,          1'b1, 32'd0,  1'b0},
		'{OP_FREE,    13'd0,    32'hFFFF_FFFF,   1'b1, 32'd0,  1'b0},
		'{OP_NONE,    13'd4096, 32'hFFFF_FFFF,   1'b1, 32'd0,  1'b0},
		'{OP_ALLOC,   13'd0,    32'd0,           1'b0, 32'd0,  1'b0},
		'{OP_RELEASE, 13'd0,    32'd0,           1'b1, 32'd0,  1'b0},
		'{OP_ALLOC,   13'd4080, 32'd0,           1'b1, 32'd16, 1'b0},
		'{OP_ALLOC,   13'd0,    32'd0,           1'b1, 32'd0,  1'b1},
		'{OP_FREE,    13'd0,    32'd16,          1'b1, 32'd0,  1'b0},
		'{OP_ALLOC,   13'd100,  32'd0,           1'b0, 32'd0,  1'b0},
		'{OP_ALLOC,   13'd3964, 32'd0,           1'b0, 32'd0,  1'b0},
		'{OP_FREE,    13'd0,    32'd16,          1'b1, 32'd0,  1'b0},
		'{OP_ALLOC,   13'd90,   32'd0,           1'b0, 32'd0,  1'b0},
		'{OP_FREE,    13'd0,    32'd132,         1'b1, 32'd0,  1'b0},
		'{OP_ALLOC,   13'd3948, 32'd0,           1'b0, 32'd0,  1'b0},
		'{OP_ALLOC,   13'd5,    32'd0,           1'b0, 32'd0,  1'b0},
		'{OP_FREE,    13'd0,    32'd17,          1'b1, 32'd0,  1'b0},
		'{OP_RELEASE, 13'd8191, 32'hFFFF_FFFF,   1'b1, 32'd0,  1'b0},
		'{OP_ALLOC,   13'd4081, 32'd0,           1'b1, 32'd0,  1'b1},
		'{OP_FREE,    13'd0,    32'd0,           1'b1, 32'd0,  1'b0}
	};

	first_fit_block_allocator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.done       (done),
		.result     (result),
		.base_we    (base_we),
		.base_wdata (base_wdata)
	);

	always #1 clk = ~clk;

	task automatic predict_heap(input cmd_t c, output result_t r);
		int unsigned cur;
		int unsigned blk;
		int unsigned need;
		int unsigned sz;
		logic [31:0] off;
		bit          hit;
		r = '0;
		hit = 1'b0;
		cur = 0;
		blk = 0;
		need = c.request_bytes;
		case (c.op)
			OP_ALLOC: begin
				while (!hit && cur < heap_top && cur < HEAP_BYTES) begin
					if (!hdr_mem[cur].busy && hdr_mem[cur].size >= need) begin
						hit = 1'b1;
						blk = cur;
					end else begin
						cur += HDR_BYTES + hdr_mem[cur].size;
					end
				end
				if (hit) begin
					sz = hdr_mem[blk].size;
					if (sz - need > HDR_BYTES) begin
						hdr_mem[blk + HDR_BYTES + need] = '{busy: 1'b0,
							size: SIZE_W'(sz - need - HDR_BYTES)};
						sz = need;
					end
					hdr_mem[blk] = '{busy: 1'b1, size: SIZE_W'(sz)};
					r.data_address = heap_base + blk + HDR_BYTES;
				end else if (HEAP_BYTES - heap_top >= HDR_BYTES + need) begin
					blk = heap_top;
					hdr_mem[blk] = '{busy: 1'b1, size: SIZE_W'(need)};
					heap_top = blk + HDR_BYTES + need;
					r.data_address = heap_base + blk + HDR_BYTES;
				end else begin
					r.status = 1'b1;
				end
			end
			OP_FREE: begin
				off = c.free_address - heap_base - 32'd16;
				while (!hit && cur < heap_top && cur < HEAP_BYTES) begin
					if (cur == off)
						hit = 1'b1;
					else
						cur += HDR_BYTES + hdr_mem[cur].size;
				end
				if (hit)
					hdr_mem[cur].busy = 1'b0;
			end
			OP_RELEASE: begin
				heap_top = 0;
			end
			default: begin
			end
		endcase
	endtask

	task automatic issue(input cmd_t c, input bit known, input result_t want);
		result_t r;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_heap(c, r);
		if (c.op == OP_ALLOC && !r.status)
			live_blocks.push_back(r.data_address - heap_base - 32'd16);
		if (c.op == OP_RELEASE)
			live_blocks.delete();
		pending_results.push_back(known ? want : r);
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0 || busy) @(posedge clk);
	endtask

	task automatic set_base(input logic [31:0] v);
		settle();
		base_we <= 1'b1;
		base_wdata <= v;
		@(posedge clk);
		base_we <= 1'b0;
		heap_base = v;
	endtask

	function automatic logic [12:0] pick_size();
		int p;
		p = $urandom_range(0, 99);
		if (p < 65)
			return 13'($urandom_range(0, 64));
		else if (p < 88)
			return 13'($urandom_range(0, 512));
		else if (p < 98)
			return 13'($urandom_range(0, 4096));
		else
			return p[0] ? 13'd4096 : 13'd4080;
	endfunction

	function automatic cmd_t random_item();
		cmd_t c;
		int   p;
		int   k;
		c.op = OP_ALLOC;
		c.request_bytes = pick_size();
		c.free_address = $urandom;
		p = $urandom_range(0, 99);
		if (p >= 55 && p < 85) begin
			c.op = OP_FREE;
			c.request_bytes = 13'($urandom_range(0, 8191));
			if (live_blocks.size() != 0 && $urandom_range(0, 4) != 0) begin
				k = $urandom_range(0, live_blocks.size() - 1);
				c.free_address = heap_base + live_blocks[k] + 32'd16;
				if ($urandom_range(0, 99) < 85)
					live_blocks.delete(k);
			end else if ($urandom_range(0, 1) == 0) begin
				c.free_address = heap_base + 32'($urandom_range(0, 4200));
			end
		end else if (p >= 85 && p < 89) begin
			c.op = OP_RELEASE;
			c.request_bytes = 13'($urandom_range(0, 8191));
		end else if (p >= 89 && p < 92) begin
			c.op = OP_NONE;
			c.request_bytes = 13'($urandom_range(0, 8191));
		end
		return c;
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual addr %h status %b",
					$time, result.data_address, result.status);
				fault_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.data_address !== want.data_address) begin
					$display("%0t: data_address mismatch, expected %h, actual %h",
						$time, want.data_address, result.data_address);
					fault_count++;
				end
				if (result.status !== want.status) begin
					$display("%0t: status mismatch, expected %b, actual %b",
						$time, want.status, result.status);
					fault_count++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		logic [31:0] phase_base [NUM_PHASES];
		cmd_t        c;
		result_t     want;
		phase_base = '{32'hFFFF_FFFF, 32'hFFFF_FFF0, $urandom, 32'h8000_0000,
			32'h0000_1000, $urandom, 32'h0000_0000};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_base(32'h0000_0000);
		for (int i = 0; i < DIR_ROWS; i++) begin
			c.op = dir_tab[i].op;
			c.request_bytes = dir_tab[i].req;
			c.free_address = dir_tab[i].faddr;
			want.data_address = dir_tab[i].want_addr;
			want.status = dir_tab[i].want_status;
			issue(c, dir_tab[i].known, want);
		end
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			set_base(phase_base[ph]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0)
					idle_on = (ph != NUM_PHASES - 1) && ($urandom_range(0, 2) != 0);
				issue(random_item(), 1'b0, '0);
			end
		end
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
src/ffba_pkg.sv
src/first_fit_block_allocator.sv
tb/sv/tb.sv
